// ----- rtl/wheel_speed_pi_regulator_unit_macros.svh -----
// assertion macros shared by the wheel speed regulator rtl
`ifndef WHEEL_SPEED_PI_REGULATOR_UNIT_MACROS_SVH
`define WHEEL_SPEED_PI_REGULATOR_UNIT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define WSPR_CHECK(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("wspr check failed");

// consequence that must hold in the cycle after the antecedent
`define WSPR_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wspr sequence check failed");

`endif

// ----- rtl/wspr_pkg.sv -----
// shared types and constants for the wheel speed regulator
package wspr_pkg;

  // field widths
  localparam int ORDER_W   = 14;
  localparam int COEF_W    = 16;
  localparam int TARGET_W  = 20;
  localparam int DUTY_W    = 17;
  localparam int ENC_W     = 16;
  localparam int PCT_W     = 7;
  localparam int LEFT_W    = 21;
  localparam int REM_W     = 22;
  localparam int ERR_W     = 21;
  localparam int TICKS_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;

  // fixed-point constants
  localparam logic [TICKS_W-1:0] MID_COUNT = TICKS_W'(32768);
  localparam logic [DUTY_W-1:0]  DUTY_FULL = DUTY_W'(65536);
  localparam logic [MUL_A_W-1:0] PCT_SCALE = MUL_A_W'(100);
  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  // largest tick count one sample can report
  localparam int TICKS_MAX_I = (32768 > 65535 - 32768) ? 32768 : 65535 - 32768;
  localparam logic [TICKS_W-1:0] TICKS_MAX = TICKS_W'(TICKS_MAX_I);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PREV  = 2'd3;

  // configuration reset values
  localparam logic [ORDER_W-1:0] SETPOINT_RST   = ORDER_W'(3840);
  localparam logic [COEF_W-1:0]  TICK_SCALE_RST = COEF_W'(4506);
  localparam logic [COEF_W-1:0]  GAIN_NOW_RST   = COEF_W'(7950);
  localparam logic [COEF_W-1:0]  GAIN_PREV_RST  = COEF_W'(6698);

  // item function codes
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // configuration seen by the datapath
  typedef struct packed {
    logic [ORDER_W-1:0] speed_setpoint;
    logic [COEF_W-1:0]  tick_speed_scale;
    logic [COEF_W-1:0]  gain_now;
    logic [COEF_W-1:0]  gain_prev;
  } cfg_t;

endpackage

// ----- rtl/wspr_channel_if.sv -----
// handshake channels of the wheel speed regulator: command, status and configuration
interface wspr_cmd_if import wspr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [TARGET_W-1:0] target_ticks;
  logic [DUTY_W-1:0]   initial_duty;
  logic [ENC_W-1:0]    encoder_count;

  modport source (output valid, func, target_ticks, initial_duty, encoder_count,
                  input ready);
  modport sink (input valid, func, target_ticks, initial_duty, encoder_count,
                output ready);
endinterface

interface wspr_status_if import wspr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PCT_W-1:0]         duty_percent;
  logic                     brake;
  logic signed [LEFT_W-1:0] ticks_left;

  modport source (output valid, duty_percent, brake, ticks_left, input ready);
  modport sink (input valid, duty_percent, brake, ticks_left, output ready);
endinterface

interface wspr_cfg_if import wspr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/wheel_speed_pi_regulator_unit.sv -----
// wheel speed regulator: incremental pi law on one shared multiplier
// a start item or a sample with no ticks left goes through S_PCT and S_OUT; an active sample
//   through S_SPEED, S_ERR, S_NOW, S_PREV, S_SUM, S_PCT, S_OUT (four products, one multiplier)
// S_OUT waits for a free status slot; cmd.ready is high only while the sequencer is idle
// reset (rst, synchronous): registers to defaults, tick count, previous error and duty zero
module wheel_speed_pi_regulator_unit import wspr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  wspr_cmd_if.sink      cmd,
  wspr_status_if.source status,
  wspr_cfg_if.sink      cfg
);

`include "wheel_speed_pi_regulator_unit_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_SPEED, S_ERR, S_NOW, S_PREV, S_SUM, S_PCT, S_OUT
  } state_t;

  state_t                     state;
  cfg_t                       regs;
  logic signed [REM_W-1:0]    remaining_ticks;
  logic signed [ERR_W-1:0]    previous_error;
  logic [DUTY_W-1:0]          previous_duty;
  logic [DUTY_W-1:0]          current_duty;
  logic [TICKS_W-1:0]         ticks;
  logic signed [ERR_W-1:0]    err;
  logic signed [PROD_W-1:0]   acc;
  logic signed [PROD_W-1:0]   prod;
  logic [MUL_A_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic [TICKS_W-1:0]         ticks_next;
  logic [23:0]                speed;
  logic signed [24:0]         speed_err;
  logic signed [ERR_W-1:0]    err_next;
  logic signed [PROD_W-1:0]   delta;
  logic signed [32:0]         duty_sum;
  logic [DUTY_W-1:0]          duty_next;
  logic [DUTY_W-1:0]          start_duty;
  logic                       out_free;

  // configuration registers
  wspr_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      S_SPEED: begin
        mul_a = MUL_A_W'(regs.tick_speed_scale);
        mul_b = $signed({{(MUL_B_W-TICKS_W){1'b0}}, ticks});
      end
      S_NOW: begin
        mul_a = MUL_A_W'(regs.gain_now);
        mul_b = MUL_B_W'(err);
      end
      S_PREV: begin
        mul_a = MUL_A_W'(regs.gain_prev);
        mul_b = MUL_B_W'(previous_error);
      end
      // percent product is held while the result waits
      S_PCT, S_OUT: begin
        mul_a = PCT_SCALE;
        mul_b = $signed({{(MUL_B_W-DUTY_W){1'b0}}, current_duty});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wspr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // ticks done since the last read
  assign ticks_next = ({1'b0, cmd.encoder_count} > MID_COUNT)
                    ? TICKS_W'({1'b0, cmd.encoder_count} - MID_COUNT)
                    : TICKS_W'(MID_COUNT - {1'b0, cmd.encoder_count});

  // speed error from the speed product, saturated
  always_comb begin
    speed     = prod[31:8];
    speed_err = $signed({11'b0, regs.speed_setpoint}) - $signed({1'b0, speed});
    if (speed_err < ERR_MIN) begin
      err_next = ERR_MIN;
    end else if (speed_err > ERR_MAX) begin
      err_next = ERR_MAX;
    end else begin
      err_next = speed_err[ERR_W-1:0];
    end
  end

  // duty update: floor of the product difference plus previous duty, clamped
  always_comb begin
    delta    = acc - prod;
    duty_sum = 33'($signed(delta[PROD_W-1:8])) + $signed({16'b0, previous_duty});
    if (duty_sum[32]) begin
      duty_next = '0;
    end else if (duty_sum[31:0] > 32'(DUTY_FULL)) begin
      duty_next = DUTY_FULL;
    end else begin
      duty_next = duty_sum[DUTY_W-1:0];
    end
  end

  // start duty saturates at full
  assign start_duty = (cmd.initial_duty > DUTY_FULL) ? DUTY_FULL : cmd.initial_duty;

  assign out_free  = !status.valid || status.ready;
  assign cmd.ready = (state == S_IDLE);

  // sequencer, regulator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      remaining_ticks <= '0;
      previous_error  <= '0;
      previous_duty   <= '0;
      current_duty    <= '0;
      status.valid    <= 1'b0;
    end else begin
      // a taken result clears unless a new one is loaded below
      if (status.valid && status.ready && state != S_OUT) begin
        status.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.func == FUNC_START) begin
              remaining_ticks <= $signed({2'b0, cmd.target_ticks});
              current_duty    <= start_duty;
              previous_error  <= '0;
              previous_duty   <= '0;
              state           <= S_PCT;
            end else if (remaining_ticks > 0) begin
              ticks <= ticks_next;
              state <= S_SPEED;
            end else begin
              state <= S_PCT;
            end
          end
        end
        S_SPEED: state <= S_ERR;
        S_ERR: begin
          err   <= err_next;
          state <= S_NOW;
        end
        S_NOW: state <= S_PREV;
        S_PREV: begin
          acc   <= prod;
          state <= S_SUM;
        end
        S_SUM: begin
          remaining_ticks <= remaining_ticks - $signed({{(REM_W-TICKS_W){1'b0}}, ticks});
          current_duty    <= duty_next;
          previous_duty   <= duty_next;
          previous_error  <= err;
          state           <= S_PCT;
        end
        S_PCT: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            status.valid        <= 1'b1;
            status.duty_percent <= prod[16 +: PCT_W];
            status.brake        <= remaining_ticks[REM_W-1] || (remaining_ticks == '0);
            status.ticks_left   <= remaining_ticks[LEFT_W-1:0];
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // duty never exceeds full scale
  `WSPR_CHECK(a_duty_range, current_duty <= DUTY_FULL)
  // previous duty is either cleared by a start or tracks the current duty
  `WSPR_CHECK(a_prev_duty, previous_duty == '0 || previous_duty == current_duty)
  // the count can only overshoot zero by one sample's worth of ticks
  `WSPR_CHECK(a_overshoot, remaining_ticks >= -$signed({{(REM_W-TICKS_W){1'b0}}, TICKS_MAX}))
  // an accepted item keeps the sequencer busy
  `WSPR_CHECK_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, state != S_IDLE)

endmodule

// ----- rtl/wspr_cfg_regs.sv -----
// configuration register file of the wheel speed regulator
module wspr_cfg_regs import wspr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wspr_cfg_if.sink  cfg,
  output cfg_t      regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.speed_setpoint   <= SETPOINT_RST;
      regs.tick_speed_scale <= TICK_SCALE_RST;
      regs.gain_now         <= GAIN_NOW_RST;
      regs.gain_prev        <= GAIN_PREV_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SETPOINT:   regs.speed_setpoint   <= cfg.data[ORDER_W-1:0];
        CFG_TICK_SCALE: regs.tick_speed_scale <= cfg.data[COEF_W-1:0];
        CFG_GAIN_NOW:   regs.gain_now         <= cfg.data[COEF_W-1:0];
        CFG_GAIN_PREV:  regs.gain_prev        <= cfg.data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/wspr_mul.sv -----
// shared signed multiplier with registered product
module wspr_mul import wspr_pkg::*; (
  input  logic                      clk,
  input  logic [MUL_A_W-1:0]        a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  // unsigned coefficient times signed operand
  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, a}) * b;
  end

endmodule
